[src/qbs_pkg.sv]
// Shared types, constants and helpers for the quadratic B-spline surface evaluator.
package qbs_pkg;

	localparam int MAX_SIDE   = 16;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W     = $clog2(GRID_DEPTH);
	localparam int SIZE_W     = 5;
	localparam int PARAM_W    = 17;
	localparam int OUT_W      = 32;
	localparam int ACC_W      = 38;

	localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_SIZE_U = 1'b0,
		REG_SIZE_V = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_BASIS,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                         op;
		logic [ADDR_W-1:0]            point_index;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
		logic [PARAM_W-1:0]           param_u;
		logic [PARAM_W-1:0]           param_v;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] surf_x;
		logic signed [OUT_W-1:0] surf_y;
		logic signed [OUT_W-1:0] surf_z;
	} out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		point_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} grid_ctl_t;

	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}));
		lo = ACC_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}));
		if (v > hi) return hi[OUT_W-1:0];
		if (v < lo) return lo[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

endpackage

[src/qbs_grid.sv]
// Control point store: one write port, one registered read port.
module qbs_grid import qbs_pkg::*; (
	input  logic      clk,
	input  grid_ctl_t ctl,
	output point_t    rd_q
);

	point_t mem [GRID_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rd_q <= mem[ctl.raddr];
	end

endmodule

[src/quadratic_bspline_surface_eval.sv]
// Top level: uniform quadratic B-spline surface evaluator with control point grid.
//
//  channel | ports                          | beat taken when
//  --------+--------------------------------+-------------------------
//  command | start, busy, cmd               | start high, busy low
//  result  | done, res                      | done high (one cycle)
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we high
//
// A point write is written to the grid on accept and gives no result; busy stays low.
// An evaluate runs one split step, four basis squares and nine tensor weights
// through the one shared 17x17 multiplier, with the grid read and the weight
// registered ahead of three multiply-accumulate lanes, then a saturate step
// that registers the result together with the done strobe.
// Reset clears the sequencer and sets size_u to 4, size_v to 3; the grid is
// left as it is. The receiver cannot stall, so done is a bare strobe.
module quadratic_bspline_surface_eval import qbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_t               cmd,
	output logic              done,
	output out_t              res,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0]  size_u_q, size_v_q;
	logic [SIZE_W-1:0]  su_q, sv_q;
	logic [PARAM_W-1:0] pu_q, pv_q;
	logic [SIZE_W-1:0]  span_u_q, span_v_q;
	logic [PARAM_W-1:0] tu_q, tv_q;
	logic [PARAM_W-1:0] wu0_q, wu2_q, wv0_q, wv2_q;
	logic [1:0]         bcnt_q;
	logic [3:0]         acnt_q;
	logic [1:0]         i_q, j_q;
	logic [PARAM_W-1:0] w_s1;
	logic               acc_en_s1;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic               done_q;
	out_t               res_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_u_q <= SIZE_W'(4);
			size_v_q <= SIZE_W'(3);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SIZE_U: size_u_q <= cfg_data;
				REG_SIZE_V: size_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [SIZE_W-1:0] clamp_sz(input logic [SIZE_W-1:0] s);
		if (s < SIZE_W'(3)) return SIZE_W'(3);
		if (s > SIZE_W'(MAX_SIDE)) return SIZE_W'(MAX_SIDE);
		return s;
	endfunction

	function automatic logic [PARAM_W-1:0] clamp_p(input logic [PARAM_W-1:0] p);
		return (p > ONE_Q16) ? ONE_Q16 : p;
	endfunction

	// span split: scaled = p * (size - 2), integer part is the span start
	localparam int SC_W = PARAM_W + SIZE_W;
	logic [SC_W-1:0]    sc_u, sc_v;
	logic [SIZE_W-1:0]  sp_u, sp_v;
	logic [PARAM_W-1:0] t_u, t_v;

	always_comb begin
		sc_u = SC_W'(pu_q) * SC_W'(su_q - SIZE_W'(2));
		sc_v = SC_W'(pv_q) * SC_W'(sv_q - SIZE_W'(2));
		sp_u = sc_u[SIZE_W+15:16];
		sp_v = sc_v[SIZE_W+15:16];
		t_u  = PARAM_W'(sc_u[15:0]);
		t_v  = PARAM_W'(sc_v[15:0]);
		// end of the parameter range: stay on the last span, t = 1
		if (sp_u > su_q - SIZE_W'(3)) begin
			sp_u = su_q - SIZE_W'(3);
			t_u  = ONE_Q16;
		end
		if (sp_v > sv_q - SIZE_W'(3)) begin
			sp_v = sv_q - SIZE_W'(3);
			t_v  = ONE_Q16;
		end
	end

	// shared multiplier
	localparam int P_W = 2 * PARAM_W;
	logic [PARAM_W-1:0] mul_a, mul_b;
	logic [P_W-1:0]     mul_p;
	logic [P_W:0]       bas_r, ten_r;
	logic [PARAM_W-1:0] wu_sel, wv_sel;
	logic [PARAM_W-1:0] wu1, wv1;

	assign wu1 = ONE_Q16 - wu0_q - wu2_q;
	assign wv1 = ONE_Q16 - wv0_q - wv2_q;

	always_comb begin
		case (j_q)
			2'd0:    wu_sel = wu0_q;
			2'd1:    wu_sel = wu1;
			default: wu_sel = wu2_q;
		endcase
		case (i_q)
			2'd0:    wv_sel = wv0_q;
			2'd1:    wv_sel = wv1;
			default: wv_sel = wv2_q;
		endcase
		if (state_q == ST_BASIS) begin
			case (bcnt_q)
				2'd0:    mul_a = ONE_Q16 - tu_q;
				2'd1:    mul_a = tu_q;
				2'd2:    mul_a = ONE_Q16 - tv_q;
				default: mul_a = tv_q;
			endcase
			mul_b = mul_a;
		end else begin
			mul_a = wu_sel;
			mul_b = wv_sel;
		end
		mul_p = P_W'(mul_a) * P_W'(mul_b);
		// squares go Q0.32 -> Q0.16 with a halving (Q0.33), tensor Q0.32 -> Q0.16
		bas_r = (P_W+1)'(mul_p) + (P_W+1)'(1 << (33 - FRAC_BITS - 1));
		ten_r = (P_W+1)'(mul_p) + (P_W+1)'(1 << (FRAC_BITS - 1));
	end

	// grid
	grid_ctl_t gctl;
	point_t    gpt;
	logic [ADDR_W-1:0] raddr;

	assign raddr = (ADDR_W'(span_v_q) + ADDR_W'(i_q)) * ADDR_W'(su_q)
	             + ADDR_W'(span_u_q) + ADDR_W'(j_q);

	always_comb begin
		gctl.we    = accept && (op_t'(cmd.op) == OP_WRITE);
		gctl.waddr = cmd.point_index;
		gctl.wdata = '{x: cmd.point_x, y: cmd.point_y, z: cmd.point_z};
		gctl.raddr = raddr;
	end

	qbs_grid u_grid (
		.clk  (clk),
		.ctl  (gctl),
		.rd_q (gpt)
	);

	// multiply-accumulate lanes: coordinate times unsigned weight
	logic signed [PARAM_W:0]            w_sgn;
	logic signed [COORD_BITS+PARAM_W:0] prod_x, prod_y, prod_z;

	assign w_sgn  = signed'({1'b0, w_s1});
	assign prod_x = gpt.x * w_sgn;
	assign prod_y = gpt.y * w_sgn;
	assign prod_z = gpt.z * w_sgn;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && op_t'(cmd.op) == OP_EVAL) state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_BASIS;
			ST_BASIS: if (bcnt_q == 2'd3) state_d = ST_ACC;
			ST_ACC:   if (acnt_q == 4'd9) state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bcnt_q    <= '0;
			acnt_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			acc_en_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_OUT);
			bcnt_q  <= (state_q == ST_BASIS) ? bcnt_q + 2'd1 : 2'd0;
			if (state_q == ST_ACC) begin
				acnt_q <= acnt_q + 4'd1;
				if (j_q == 2'd2) begin
					j_q <= 2'd0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end else begin
				acnt_q <= '0;
				i_q    <= '0;
				j_q    <= '0;
			end
			acc_en_s1 <= (state_q == ST_ACC) && (acnt_q < 4'd9);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			su_q <= clamp_sz(size_u_q);
			sv_q <= clamp_sz(size_v_q);
			pu_q <= clamp_p(cmd.param_u);
			pv_q <= clamp_p(cmd.param_v);
		end
		if (state_q == ST_SPLIT) begin
			span_u_q <= sp_u;
			span_v_q <= sp_v;
			tu_q     <= t_u;
			tv_q     <= t_v;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_z_q  <= '0;
		end
		if (state_q == ST_BASIS) begin
			case (bcnt_q)
				2'd0:    wu0_q <= bas_r[33:33-FRAC_BITS-1+1+0] ;
				2'd1:    wu2_q <= bas_r[33:17];
				2'd2:    wv0_q <= bas_r[33:17];
				default: wv2_q <= bas_r[33:17];
			endcase
		end
		w_s1 <= ten_r[32:16];
		if (acc_en_s1) begin
			acc_x_q <= acc_x_q + ACC_W'(prod_x);
			acc_y_q <= acc_y_q + ACC_W'(prod_y);
			acc_z_q <= acc_z_q + ACC_W'(prod_z);
		end
		if (state_q == ST_OUT) begin
			res_q.surf_x <= sat32(acc_x_q);
			res_q.surf_y <= sat32(acc_y_q);
			res_q.surf_z <= sat32(acc_z_q);
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_OUT))
		else $error("done without a finished evaluation");
	a_eval_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op) |=> busy)
		else $error("evaluate accepted but block not busy");
	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cmd.op) |=> !busy)
		else $error("point write made the block busy");
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (acnt_q <= 4'd9))
		else $error("accumulate counter overran");
`endif

endmodule

[sim/tb_quadratic_bspline_surface_eval.sv]
// Testbench for the quadratic B-spline surface evaluator: directed table, then random beats.
module tb_quadratic_bspline_surface_eval;
	import qbs_pkg::*;

	// Cycles without any beat, command or result, before the run is declared hung.
	localparam int HANG_LIMIT  = 600;
	// Settle time after the last result: a bit over one evaluate.
	localparam int SETTLE      = 24;
	localparam int RANDOM_ITEMS = 680;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	in_t          cmd = '0;
	logic         done;
	out_t         res;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;

	quadratic_bspline_surface_eval DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block: grid contents and the two size registers.
	point_t            shadow_grid [GRID_DEPTH];
	logic [SIZE_W-1:0] shadow_size_u = SIZE_W'(4);
	logic [SIZE_W-1:0] shadow_size_v = SIZE_W'(3);

	out_t pending_surf[$];
	int   fail_count = 0;
	int   quiet_cycles = 0;
	int   beats_sent = 0;

	typedef struct {
		in_t  cmd;
		bit   typed;
		out_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// --- predictor ------------------------------------------------------

	function automatic longint clamp_side(logic [SIZE_W-1:0] s);
		if (s < 3) return 3;
		if (s > MAX_SIDE) return MAX_SIDE;
		return longint'(s);
	endfunction

	// Parameter to span start and Q0.16 fraction; the end point clamps to size-3, t=1.0
	function automatic void split_param(input logic [PARAM_W-1:0] p, input longint side,
			output longint span, output longint t);
		longint pc, scaled;
		pc = (p > ONE_Q16) ? 65536 : longint'(p);
		scaled = pc * (side - 2);
		span = scaled >>> 16;
		t = scaled & 'hFFFF;
		if (span > side - 3) begin
			span = side - 3;
			t = 65536;
		end
	endfunction

	// Basis weights in Q0.16; the middle one is taken as the remainder
	function automatic void basis_q16(input longint t, output longint w0, output longint w1,
			output longint w2);
		longint omt;
		omt = 65536 - t;
		w0 = (omt * omt + 65536) >>> 17;
		w2 = (t * t + 65536) >>> 17;
		w1 = 65536 - w0 - w2;
	endfunction

	function automatic logic signed [OUT_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[OUT_W-1:0];
	endfunction

	function automatic out_t surface_at(logic [PARAM_W-1:0] pu, logic [PARAM_W-1:0] pv);
		longint su, sv, span_u, span_v, tu, tv, w, slot;
		longint wu[3], wv[3];
		longint ax, ay, az;
		out_t r;
		su = clamp_side(shadow_size_u);
		sv = clamp_side(shadow_size_v);
		split_param(pu, su, span_u, tu);
		split_param(pv, sv, span_v, tv);
		basis_q16(tu, wu[0], wu[1], wu[2]);
		basis_q16(tv, wv[0], wv[1], wv[2]);
		ax = 0; ay = 0; az = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				w = (wu[j] * wv[i] + 32768) >>> 16;
				slot = (span_v + i) * su + (span_u + j);
				if (slot < GRID_DEPTH) begin
					ax += longint'(shadow_grid[slot].x) * w;
					ay += longint'(shadow_grid[slot].y) * w;
					az += longint'(shadow_grid[slot].z) * w;
				end
			end
		end
		r.surf_x = clip32(ax);
		r.surf_y = clip32(ay);
		r.surf_z = clip32(az);
		return r;
	endfunction

	// Apply an accepted command to the shadow state; evaluates queue their result.
	function automatic void track_command(in_t c);
		if (c.op == OP_WRITE)
			shadow_grid[c.point_index] = '{c.point_x, c.point_y, c.point_z};
		else
			pending_surf.push_back(surface_at(c.param_u, c.param_v));
	endfunction

	// --- stimulus helpers -----------------------------------------------

	function automatic in_t point_write(int slot, int x, int y, int z);
		in_t c;
		c = '0;
		c.op = OP_WRITE;
		c.point_index = slot[ADDR_W-1:0];
		c.point_x = x[15:0];
		c.point_y = y[15:0];
		c.point_z = z[15:0];
		return c;
	endfunction

	function automatic in_t eval_at(int u, int v);
		in_t c;
		c = '0;
		c.op = OP_EVAL;
		c.param_u = u[PARAM_W-1:0];
		c.param_v = v[PARAM_W-1:0];
		return c;
	endfunction

	function automatic logic signed [15:0] rand_coord();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 16'sh7FFF;
		if (k == 1) return 16'sh8000;
		if (k == 2) return 16'($urandom_range(0, 15)) - 16'sd8;
		return 16'($urandom);
	endfunction

	function automatic logic [PARAM_W-1:0] rand_param();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return ONE_Q16;
		if (k == 1) return 17'd0;
		if (k == 2) return 17'($urandom);
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic in_t rand_command();
		in_t c;
		c = '0;
		if ($urandom_range(0, 99) < 35) begin
			c.op = OP_WRITE;
			c.point_index = 8'($urandom);
			c.point_x = rand_coord();
			c.point_y = rand_coord();
			c.point_z = rand_coord();
			// params are don't-care on a write: throw noise on them
			c.param_u = 17'($urandom);
			c.param_v = 17'($urandom);
		end else begin
			c.op = OP_EVAL;
			c.param_u = rand_param();
			c.param_v = rand_param();
			c.point_index = 8'($urandom);
			c.point_x = 16'($urandom);
		end
		return c;
	endfunction

	// Hold the beat on the bus until the block takes it; idle_pct sets the chance of gaps.
	task automatic send_beat(in_t c, int idle_pct);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct && gap < 20) begin
			start <= 1'b0;
			@(posedge clk);
			gap++;
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		track_command(c);
		beats_sent++;
	endtask

	// Sender holds off until the last result is back, then lets the block go quiet.
	task automatic drain();
		start <= 1'b0;
		while (pending_surf.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_sizes(logic [SIZE_W-1:0] su, logic [SIZE_W-1:0] sv);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_SIZE_U;
		cfg_data <= su;
		@(posedge clk);
		shadow_size_u = su;
		cfg_index <= REG_SIZE_V;
		cfg_data <= sv;
		@(posedge clk);
		shadow_size_v = sv;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int idle_for_beat();
		if (beats_sent < 320) return 29;
		if (beats_sent < 640) return 57;
		return 0;
	endfunction

	// --- result check and hang watch ------------------------------------

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		fail_count++;
		$display("%0t %s expected %h actual %h", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (done) begin
				if (pending_surf.size() == 0) begin
					report("unexpected result", 32'h0, res.surf_x);
				end else begin
					out_t want;
					want = pending_surf.pop_front();
					if (res.surf_x !== want.surf_x) report("surf_x", want.surf_x, res.surf_x);
					if (res.surf_y !== want.surf_y) report("surf_y", want.surf_y, res.surf_y);
					if (res.surf_z !== want.surf_z) report("surf_z", want.surf_z, res.surf_z);
				end
			end
		end
	end

	// --- main sequence --------------------------------------------------

	initial begin
		out_t flat;
		logic [SIZE_W-1:0] size_plan [8][2];

		// Constant grid: at the ends and at zero the tensor weights sum to exactly one,
		// so the surface sits on the constant point.
		flat.surf_x = 32'sh7FFF0000;
		flat.surf_y = 32'sh80000000;
		flat.surf_z = 32'shFFFF0000;

		dir_rows.push_back('{eval_at(0, 0), 1'b1, flat});
		dir_rows.push_back('{eval_at(65536, 65536), 1'b1, flat});
		dir_rows.push_back('{eval_at(131071, 0), 1'b1, flat});	// above one saturates
		dir_rows.push_back('{eval_at(0, 131071), 1'b1, flat});
		dir_rows.push_back('{eval_at(65536, 0), 1'b1, flat});
		dir_rows.push_back('{eval_at(32768, 32768), 1'b0, flat});
		dir_rows.push_back('{point_write(0, -32768, 32767, 0), 1'b0, flat});
		dir_rows.push_back('{point_write(255, 32767, 32767, 32767), 1'b0, flat});
		dir_rows.push_back('{point_write(5, 1234, -4321, 7), 1'b0, flat});
		dir_rows.push_back('{point_write(1, -1, -1, -1), 1'b0, flat});
		dir_rows.push_back('{eval_at(0, 0), 1'b0, flat});
		dir_rows.push_back('{eval_at(1, 1), 1'b0, flat});
		dir_rows.push_back('{eval_at(65535, 65535), 1'b0, flat});
		dir_rows.push_back('{eval_at(32768, 65535), 1'b0, flat});
		dir_rows.push_back('{eval_at(98304, 21845), 1'b0, flat});

		// Sizes per phase: clamps below and above, both maxima, both minima, skew.
		size_plan = '{'{5'd16, 5'd16}, '{5'd3, 5'd3}, '{5'd0, 5'd31}, '{5'd2, 5'd17},
			'{5'd7, 5'd5}, '{5'd16, 5'd3}, '{5'd3, 5'd16}, '{5'd31, 5'd1}};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every slot gets a defined point before any evaluate reads it.
		for (int s = 0; s < GRID_DEPTH; s++)
			send_beat(point_write(s, 32767, -32768, -1), idle_for_beat());

		foreach (dir_rows[n]) begin
			if (dir_rows[n].typed) begin
				send_beat(dir_rows[n].cmd, idle_for_beat());
				// swap the predicted value for the one read off by hand
				void'(pending_surf.pop_back());
				pending_surf.push_back(dir_rows[n].want);
			end else begin
				send_beat(dir_rows[n].cmd, idle_for_beat());
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			set_sizes(size_plan[ph][0], size_plan[ph][1]);
			for (int n = 0; n < RANDOM_ITEMS / 8; n++)
				send_beat(rand_command(), idle_for_beat());
		end

		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
